/* hw/rtl/nbcs_pkg.sv */
// Types and constants shared by the nested box centre suppression block.
package nbcs_pkg;

    localparam int COORD_BITS = 12;
    localparam int SIZE_BITS  = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * SIZE_BITS;
    localparam int INDEX_BITS = 5;

    typedef struct packed {
        logic [COORD_BITS-1:0] box_x;
        logic [COORD_BITS-1:0] box_y;
        logic [SIZE_BITS-1:0]  box_width;
        logic [SIZE_BITS-1:0]  box_height;
        logic                  last_box;
    } t_in_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] box_index;
        logic                  keep;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [SIZE_BITS-1:0]  out_width;
        logic [SIZE_BITS-1:0]  out_height;
        logic                  overflowed;
        logic                  last_result;
    } t_out_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [SIZE_BITS-1:0]  w;
        logic [SIZE_BITS-1:0]  h;
    } t_box;

    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_ME,
        S_CALC,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic rd_me;
        logic scan_issue;
        logic scan_self;
        logic clr_supp;
        logic emit;
        logic overflow;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

/* hw/rtl/nbcs_ctrl.sv */
// Controller state machine: loading, per-box scan sequencing and result emission.
module nbcs_ctrl
    import nbcs_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_last_box,
    input  t_status                       i_status,
    output logic                          o_in_stall,
    output t_cmd                          o_cmd,
    output logic [$clog2(MAX_BOXES)-1:0]  o_wr_addr,
    output logic [$clog2(MAX_BOXES)-1:0]  o_me_addr,
    output logic [$clog2(MAX_BOXES)-1:0]  o_scan_addr
);

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CW = $clog2(MAX_BOXES + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [AW-1:0] r_k, n_k;
    logic [AW-1:0] r_i, n_i;

    logic          in_xfer;
    logic          full;
    logic          k_last;
    logic          i_last;

    assign in_xfer = (r_state == S_LOAD) && i_in_valid;
    assign full    = (r_count == CW'(MAX_BOXES));
    assign k_last  = ((CW'(r_k) + CW'(1)) == r_count);
    assign i_last  = ((CW'(r_i) + CW'(1)) == r_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_xfer && i_last_box) begin
                    n_state = S_RD_ME;
                end
            end
            S_RD_ME: n_state = S_CALC;
            S_CALC:  n_state = S_SCAN;
            S_SCAN: begin
                if (i_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    n_state = k_last ? S_LOAD : S_RD_ME;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        n_k     = r_k;
        n_i     = r_i;
        case (r_state)
            S_LOAD: begin
                n_k = '0;
                if (in_xfer) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            S_CALC: n_i = '0;
            S_SCAN: n_i = r_i + AW'(1);
            S_EMIT: begin
                if (i_status.out_free) begin
                    if (k_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_k = r_k + AW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_in_stall       = (r_state != S_LOAD);
        o_cmd.wr_en      = in_xfer && !full;
        o_cmd.rd_me      = (r_state == S_RD_ME);
        o_cmd.scan_issue = (r_state == S_SCAN);
        o_cmd.scan_self  = (r_i == r_k);
        o_cmd.clr_supp   = (r_state == S_CALC);
        o_cmd.emit       = (r_state == S_EMIT) && i_status.out_free;
        o_cmd.overflow   = r_ovf;
        o_cmd.last       = k_last;
        o_wr_addr        = r_count[AW-1:0];
        o_me_addr        = r_k;
        o_scan_addr      = r_i;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_k     <= '0;
            r_i     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_k     <= n_k;
            r_i     <= n_i;
        end
    end

endmodule

/* hw/rtl/nbcs_dpath.sv */
// Datapath: box memory, centre and area of the box under test, scan pipeline, output register.
module nbcs_dpath
    import nbcs_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_cmd                          i_cmd,
    input  logic [$clog2(MAX_BOXES)-1:0]  i_wr_addr,
    input  logic [$clog2(MAX_BOXES)-1:0]  i_me_addr,
    input  logic [$clog2(MAX_BOXES)-1:0]  i_scan_addr,
    input  t_in_item                      i_in_data,
    input  logic                          i_out_stall,
    output t_status                       o_status,
    output logic                          o_out_valid,
    output t_out_item                     o_out_data
);

    t_box                 r_mem [MAX_BOXES];
    t_box                 r_me;
    t_box                 r_oth;
    logic [SIZE_BITS-1:0] r_cx, r_cy;
    logic [AREA_BITS-1:0] r_my_area;
    logic                 r_v1, r_self1;
    logic                 r_v2, r_in2;
    logic [AREA_BITS-1:0] r_area2;
    logic                 r_supp;
    logic                 r_out_valid;
    t_out_item            r_out;

    t_box                 wr_box;
    logic [SIZE_BITS:0]   x_end, y_end;
    logic                 centre_in;
    logic                 out_free;

    assign wr_box.x = i_in_data.box_x;
    assign wr_box.y = i_in_data.box_y;
    assign wr_box.w = i_in_data.box_width;
    assign wr_box.h = i_in_data.box_height;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= wr_box;
        end
        if (i_cmd.rd_me) begin
            r_me <= r_mem[i_me_addr];
        end
        if (i_cmd.scan_issue) begin
            r_oth <= r_mem[i_scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx      <= SIZE_BITS'(r_me.x) + (r_me.w >> 1);
        r_cy      <= SIZE_BITS'(r_me.y) + (r_me.h >> 1);
        r_my_area <= AREA_BITS'(r_me.w) * AREA_BITS'(r_me.h);
    end

    assign x_end     = (SIZE_BITS+1)'(r_oth.x) + (SIZE_BITS+1)'(r_oth.w);
    assign y_end     = (SIZE_BITS+1)'(r_oth.y) + (SIZE_BITS+1)'(r_oth.h);
    assign centre_in = (SIZE_BITS'(r_oth.x) <= r_cx) && ((SIZE_BITS+1)'(r_cx) < x_end)
                    && (SIZE_BITS'(r_oth.y) <= r_cy) && ((SIZE_BITS+1)'(r_cy) < y_end);

    always_ff @(posedge i_clk) begin
        r_self1 <= i_cmd.scan_self;
        r_in2   <= centre_in;
        r_area2 <= AREA_BITS'(r_oth.w) * AREA_BITS'(r_oth.h);
        if (i_cmd.clr_supp) begin
            r_supp <= 1'b0;
        end else if (r_v2 && r_in2 && (r_area2 > r_my_area)) begin
            r_supp <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_issue;
            r_v2 <= r_v1 && !r_self1;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.box_index   <= INDEX_BITS'(i_me_addr);
            r_out.keep        <= !r_supp;
            r_out.out_x       <= r_me.x;
            r_out.out_y       <= r_me.y;
            r_out.out_width   <= r_me.w;
            r_out.out_height  <= r_me.h;
            r_out.overflowed  <= i_cmd.overflow;
            r_out.last_result <= i_cmd.last;
        end
    end

    assign o_status.pipe_busy = r_v1 || r_v2;
    assign o_status.out_free  = out_free;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

/* hw/rtl/nested_box_center_suppress.sv */
// Boxes are loaded one per cycle, while input is not stalled, into a MAX_BOXES-entry
// memory until an item marked last; further boxes beyond capacity are discarded and
// flagged in every result of that list. Evaluation then runs box by box: read the box,
// form its centre and area, make one pass over the stored boxes through the memory's
// second read port, drain the three-stage compare pipeline and hand the result to the
// output register, waiting while the output is stalled. Input transfers are stalled
// while a list is evaluated. The box memory is not cleared; only entries written in
// the current list are read.
module nested_box_center_suppress
    import nbcs_pkg::*;
#(
    parameter int MAX_BOXES = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int AW = $clog2(MAX_BOXES);

    t_cmd          cmd;
    t_status       status;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] me_addr;
    logic [AW-1:0] scan_addr;

    nbcs_ctrl #(
        .MAX_BOXES (MAX_BOXES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last_box  (i_in_data.last_box),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .o_wr_addr   (wr_addr),
        .o_me_addr   (me_addr),
        .o_scan_addr (scan_addr)
    );

    nbcs_dpath #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_wr_addr   (wr_addr),
        .i_me_addr   (me_addr),
        .i_scan_addr (scan_addr),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

/* sim/nested_box_center_suppress_tb.sv */
// Testbench for the nested box centre suppression block: box lists checked against a predictor.
`timescale 1ns / 100ps
module nested_box_center_suppress_tb;
    import nbcs_pkg::*;

    localparam int BOX_CAPACITY  = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 2 * (BOX_CAPACITY + 5) + 20;
    localparam int RANDOM_BOXES  = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_data;

    t_box      box_mem [BOX_CAPACITY];
    int        box_total          = 0;
    bit        capacity_hit       = 1'b0;
    t_out_item expected_verdicts [$];
    int        verdict_mismatches = 0;
    int        cycle_count        = 0;
    bit        idling_on          = 1'b1;
    int        hold_off_cycles    = 0;

    nested_box_center_suppress #(.MAX_BOXES(BOX_CAPACITY)) dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit centre_in_larger(int k);
        int unsigned     cx;
        int unsigned     cy;
        longint unsigned my_area;
        bit              hit;
        int              i;
        cx      = box_mem[k].x + box_mem[k].w / 2;
        cy      = box_mem[k].y + box_mem[k].h / 2;
        my_area = box_mem[k].w * box_mem[k].h;
        hit     = 1'b0;
        for (i = 0; i < box_total; i++) begin
            if (i != k && box_mem[i].x <= cx && cx < box_mem[i].x + box_mem[i].w
                    && box_mem[i].y <= cy && cy < box_mem[i].y + box_mem[i].h
                    && my_area < box_mem[i].w * box_mem[i].h) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic void load_box(t_in_item item);
        t_out_item v;
        int        k;
        if (box_total < BOX_CAPACITY) begin
            box_mem[box_total] = '{x: item.box_x, y: item.box_y,
                                   w: item.box_width, h: item.box_height};
            box_total++;
        end else begin
            capacity_hit = 1'b1;
        end
        if (item.last_box) begin
            for (k = 0; k < box_total; k++) begin
                v.box_index   = INDEX_BITS'(k);
                v.keep        = !centre_in_larger(k);
                v.out_x       = box_mem[k].x;
                v.out_y       = box_mem[k].y;
                v.out_width   = box_mem[k].w;
                v.out_height  = box_mem[k].h;
                v.overflowed  = capacity_hit;
                v.last_result = (k == box_total - 1);
                expected_verdicts = {expected_verdicts, v};
            end
            box_total    = 0;
            capacity_hit = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item mk_box(int x, int y, int w, int h, bit last);
        t_in_item b;
        b.box_x      = COORD_BITS'(x);
        b.box_y      = COORD_BITS'(y);
        b.box_width  = SIZE_BITS'(w);
        b.box_height = SIZE_BITS'(h);
        b.last_box   = last;
        return b;
    endfunction

    function automatic t_in_item rand_box(t_in_item parent, bit has_parent);
        int mode;
        int w;
        int h;
        int cx;
        int cy;
        mode = has_parent ? $urandom_range(0, 9) : $urandom_range(6, 9);
        if (mode < 5) begin
            // nest: centre inside the parent or on its far edge, size at most the parent's
            w  = $urandom_range(0, parent.box_width);
            h  = $urandom_range(0, parent.box_height);
            cx = parent.box_x + $urandom_range(0, parent.box_width);
            cy = parent.box_y + $urandom_range(0, parent.box_height);
            return mk_box(cx - w / 2, cy - h / 2, w, h, 1'b0);
        end
        if (mode < 6) begin
            return mk_box(parent.box_x + $urandom_range(0, 31), parent.box_y,
                          parent.box_height, parent.box_width, 1'b0);
        end
        if (mode < 8) begin
            return mk_box($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 160), $urandom_range(0, 160), 1'b0);
        end
        return mk_box($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 8191), $urandom_range(0, 8191), 1'b0);
    endfunction

    task automatic send_box(t_in_item item);
        int gap;
        gap = idling_on ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        load_box(item);
    endtask

    task automatic idle_input();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_list(int len);
        t_in_item made [$];
        t_in_item b;
        int       n;
        b = '0;
        for (n = 0; n < len; n++) begin
            if (made.size() == 0) b = rand_box(b, 1'b0);
            else b = rand_box(made[$urandom_range(0, made.size() - 1)], 1'b1);
            b.last_box = (n == len - 1);
            made = {made, b};
            send_box(b);
        end
    endtask

    task automatic test_directed();
        send_box(mk_box(0, 0, 0, 0, 1'b1));
        // nesting, equal area, zero width, far corner
        send_box(mk_box(0, 0, 4096, 4096, 1'b0));
        send_box(mk_box(100, 100, 10, 10, 1'b0));
        send_box(mk_box(200, 200, 4096, 4096, 1'b0));
        send_box(mk_box(0, 0, 0, 8191, 1'b0));
        send_box(mk_box(4095, 0, 1, 1, 1'b1));
        // half-open edges of one box, and a zero-width box over it
        send_box(mk_box(1000, 1000, 100, 100, 1'b0));
        send_box(mk_box(1100, 1050, 1, 1, 1'b0));
        send_box(mk_box(1040, 1099, 1, 1, 1'b0));
        send_box(mk_box(999, 1050, 3, 1, 1'b0));
        send_box(mk_box(999, 1050, 1, 1, 1'b0));
        send_box(mk_box(1050, 0, 0, 4096, 1'b1));
        // full-scale sizes
        send_box(mk_box(4095, 4095, 8191, 8191, 1'b0));
        send_box(mk_box(4095, 4095, 8191, 8190, 1'b1));
        // identical pair
        send_box(mk_box(50, 60, 20, 30, 1'b0));
        send_box(mk_box(50, 60, 20, 30, 1'b1));
        idle_input();
    endtask

    task automatic test_capacity();
        send_list(BOX_CAPACITY);
        send_list(BOX_CAPACITY + 1);
        send_list(BOX_CAPACITY + 3);
        idle_input();
    endtask

    task automatic test_output_hold_off();
        idling_on       = 1'b0;
        hold_off_cycles = 500;
        send_list(3);
        send_list(8);
        idling_on = 1'b1;
        idle_input();
    endtask

    task automatic test_random_lists();
        int sent;
        int len;
        int r;
        sent = 0;
        while (sent < RANDOM_BOXES) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(1, 6);
            else if (r < 95) len = $urandom_range(7, 16);
            else len = $urandom_range(17, BOX_CAPACITY + 2);
            idling_on = ($urandom_range(0, 3) != 0);
            send_list(len);
            sent += len;
        end
        idling_on = 1'b1;
        idle_input();
    endtask

    initial begin : out_stall_drive
        int run_left;
        bit stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles > 0) begin
                run_left        = hold_off_cycles;
                hold_off_cycles = 0;
                stall_now       = 1'b1;
            end else if (run_left == 0) begin
                run_left  = pick_gap() + 1;
                stall_now = idling_on && ($urandom_range(0, 2) == 0);
            end
            i_out_stall <= stall_now;
            run_left--;
        end
    end

    function automatic string describe(t_out_item r);
        return $sformatf("idx=%0d keep=%0b x=%0d y=%0d w=%0d h=%0d ovf=%0b last=%0b",
                         r.box_index, r.keep, r.out_x, r.out_y, r.out_width,
                         r.out_height, r.overflowed, r.last_result);
    endfunction

    always @(posedge i_clk) begin : verdict_check
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_verdicts.size() == 0) begin
                verdict_mismatches++;
                if (verdict_mismatches <= 10)
                    $display("unexpected transfer: %s", describe(o_out_data));
            end else begin
                want = expected_verdicts.pop_front();
                if (o_out_data.box_index !== want.box_index || o_out_data.keep !== want.keep
                        || o_out_data.out_x !== want.out_x || o_out_data.out_y !== want.out_y
                        || o_out_data.out_width !== want.out_width
                        || o_out_data.out_height !== want.out_height
                        || o_out_data.overflowed !== want.overflowed
                        || o_out_data.last_result !== want.last_result) begin
                    verdict_mismatches++;
                    if (verdict_mismatches <= 10)
                        $display("expected %s\n  actual %s", describe(want),
                                 describe(o_out_data));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_capacity();
        test_output_hold_off();
        test_random_lists();
        while (expected_verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (verdict_mismatches == 0 && expected_verdicts.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
